/* src/oledfb_pkg.sv */
// Shared types and constants for the OLED page-mode framebuffer.
// Used by the pixel store, the refresh sequencer and the top level.
`default_nettype none

package oledfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 32;

  localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
  localparam int STORE_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_SIZE  = SCREEN_WIDTH * STORE_PAGES;
  localparam int ADDR_W      = $clog2(STORE_SIZE);
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_SET_PIXEL = 2'd1,
    OP_REFRESH   = 2'd2
  } op_t;

  // Command slots that open every page of the refresh stream.
  typedef enum logic [1:0] {
    HDR_PAGE_CMD = 2'd0,
    HDR_PAGE_NUM = 2'd1,
    HDR_COL_LOW  = 2'd2,
    HDR_COL_HIGH = 2'd3
  } hdr_slot_t;

  // What the sequencer says about the next byte of the refresh stream.
  typedef struct packed {
    logic       is_data;
    logic       frame_end;
    logic [7:0] cmd_byte;
    addr_t      addr;
  } refresh_slot_t;

endpackage

`default_nettype wire

/* src/oledfb_store.sv */
// Pixel store: one synchronous memory of packed pixel columns with a
// registered read port and write-to-read forwarding. Uses oledfb_pkg.
`default_nettype none

module oledfb_store
  import oledfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,
  input  wire addr_t      rd_addr,
  output logic      [7:0] rd_data,
  input  wire logic       wr_en,
  input  wire addr_t      wr_addr,
  input  wire logic [7:0] wr_data
);

  logic [7:0] mem [STORE_SIZE];
  logic [7:0] mem_q;
  addr_t      rd_addr_q;
  addr_t      last_addr;
  logic [7:0] last_data;
  logic       last_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (wr_en) begin
      last_addr <= wr_addr;
      last_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (wr_en) begin
      last_valid <= 1'b1;
    end
  end

  // The most recent write always matches memory contents at its address,
  // so taking it covers a write that lands on the same edge as the read.
  assign rd_data = (last_valid && last_addr == rd_addr_q) ? last_data : mem_q;

endmodule

`default_nettype wire

/* src/oledfb_refresh_seq.sv */
// Refresh stream sequencer: tracks page, header slot and column, and
// describes the next stream byte. Uses oledfb_pkg.
`default_nettype none

module oledfb_refresh_seq
  import oledfb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  output refresh_slot_t slot
);

  logic [PAGE_W-1:0] page, page_next;
  logic [COL_W-1:0]  col, col_next;
  hdr_slot_t         hdr, hdr_next;
  logic              in_data, in_data_next;
  logic              last_col, last_page;

  assign last_col  = (col == COL_W'(SCREEN_WIDTH - 1));
  assign last_page = (page == PAGE_W'(PAGE_COUNT - 1));

  always_comb begin
    slot.is_data   = in_data;
    slot.frame_end = in_data && last_col && last_page;
    slot.addr      = addr_t'(addr_t'(page) * addr_t'(SCREEN_WIDTH) + addr_t'(col));
    case (hdr)
      HDR_PAGE_CMD: slot.cmd_byte = CMD_PAGE_ADDR;
      HDR_PAGE_NUM: slot.cmd_byte = 8'(page);
      HDR_COL_LOW:  slot.cmd_byte = CMD_COL_LOW;
      HDR_COL_HIGH: slot.cmd_byte = CMD_COL_HIGH;
      default:      slot.cmd_byte = CMD_COL_LOW;
    endcase
  end

  always_comb begin
    page_next    = page;
    col_next     = col;
    hdr_next     = hdr;
    in_data_next = in_data;
    if (!in_data) begin
      if (hdr == HDR_COL_HIGH) begin
        in_data_next = 1'b1;
        col_next     = '0;
      end else begin
        hdr_next = hdr_slot_t'(hdr + 2'd1);
      end
    end else if (last_col) begin
      in_data_next = 1'b0;
      hdr_next     = HDR_PAGE_CMD;
      page_next    = last_page ? '0 : PAGE_W'(page + 1'b1);
    end else begin
      col_next = COL_W'(col + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page    <= '0;
      col     <= '0;
      hdr     <= HDR_PAGE_CMD;
      in_data <= 1'b0;
    end else if (step) begin
      page    <= page_next;
      col     <= col_next;
      hdr     <= hdr_next;
      in_data <= in_data_next;
    end
  end

endmodule

`default_nettype wire

/* src/oled_page_framebuffer_refresh_core.sv */
// Top level of the OLED page-mode framebuffer with its refresh stream.
// Uses oledfb_pkg, oledfb_store and oledfb_refresh_seq.
//
// Set-pixel and refresh-step requests are taken one per cycle: a request
// reads the pixel store in the cycle it is accepted, and the following
// stage merges the pixel and writes back, or loads the output register
// with the refresh byte. A refresh byte that cannot move into the output
// register because the response side is stalled holds off new requests
// until it does. Back-to-back writes and reads of the same column
// byte are forwarded. A clear request, and reset, start a sweep that zeroes
// all STORE_SIZE bytes of the store (512 at 128x32) one byte per cycle,
// and requests are stalled while it runs. The refresh stream position
// survives a clear.
`default_nettype none

module oled_page_framebuffer_refresh_core
  import oledfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic        [1:0] operation,
  input  wire logic signed [8:0] pixel_x,
  input  wire logic signed [8:0] pixel_y,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic             [7:0] out_byte,
  output logic                   is_data,
  output logic                   frame_end
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CLEAR = 2'b10
  } state_t;

  state_t        state;
  addr_t         sweep;
  op_t           op;
  logic          accept;
  logic          set_ok;
  addr_t         set_addr;
  refresh_slot_t slot;
  logic          rd_en;
  addr_t         rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  addr_t         wr_addr;
  logic [7:0]    wr_data;

  logic          b_valid;
  logic          b_is_set;
  addr_t         b_addr;
  logic [7:0]    b_mask;
  refresh_slot_t b_slot;
  logic          b_blocked;
  logic          clearing;

  assign op       = op_t'(operation);
  assign clearing = (state == ST_CLEAR);
  assign b_blocked = b_valid && !b_is_set && rsp_valid && rsp_stall;
  assign req_stall = clearing || b_blocked;
  assign accept    = req_valid && !req_stall;

  assign set_ok = !pixel_x[8] && ($unsigned(pixel_x) < 9'(SCREEN_WIDTH)) &&
                  !pixel_y[8] && ($unsigned(pixel_y) < 9'(SCREEN_HEIGHT));
  assign set_addr = addr_t'(addr_t'(pixel_y[8:3]) * addr_t'(SCREEN_WIDTH) +
                            addr_t'(pixel_x[7:0]));

  oledfb_refresh_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (accept && op == OP_REFRESH),
    .slot (slot)
  );

  assign rd_en   = accept;
  assign rd_addr = (op == OP_SET_PIXEL) ? set_addr : slot.addr;

  assign wr_en   = clearing || (b_valid && b_is_set);
  assign wr_addr = clearing ? sweep : b_addr;
  assign wr_data = clearing ? 8'h00 : (rd_data | b_mask);

  oledfb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (accept && op == OP_CLEAR) begin
            state <= ST_CLEAR;
            sweep <= '0;
          end
        end
        ST_CLEAR: begin
          sweep <= addr_t'(sweep + 1'b1);
          if (sweep == addr_t'(STORE_SIZE - 1)) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_CLEAR;
          sweep <= '0;
        end
      endcase
    end
  end

  // Read-modify-write stage; the store's read data is valid here.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= (op == OP_SET_PIXEL && set_ok) || (op == OP_REFRESH);
    end else if (!b_blocked) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_is_set <= (op == OP_SET_PIXEL);
      b_addr   <= set_addr;
      b_mask   <= 8'(8'd1 << pixel_y[2:0]);
      b_slot   <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (b_valid && !b_is_set && !(rsp_valid && rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && !b_is_set && !(rsp_valid && rsp_stall)) begin
      out_byte  <= b_slot.is_data ? rd_data : b_slot.cmd_byte;
      is_data   <= b_slot.is_data;
      frame_end <= b_slot.frame_end;
    end
  end

endmodule

`default_nettype wire

/* sim/oled_page_framebuffer_refresh_core_tb.sv */
// Self-checking testbench for the OLED page-mode framebuffer core.
// It drives directed and random requests and checks every refresh byte against the local model or a fixed value.
// Depends on oledfb_pkg and oled_page_framebuffer_refresh_core.

module oled_page_framebuffer_refresh_core_tb
  import oledfb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HEADER_SLOTS = 4;
  localparam int RANDOM_ITEMS = 776;
  localparam int QUIET_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIRECTED_ROWS = 24;

  typedef struct packed {
    logic [7:0] bits;
    logic       data_flag;
    logic       frame_last;
  } stream_byte_t;

  typedef struct {
    logic [1:0]        op;
    logic signed [8:0] x;
    logic signed [8:0] y;
    bit                typed;
    stream_byte_t      want;
  } directed_row_t;

  localparam stream_byte_t NO_BYTE = '0;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic        [1:0] operation;
  logic signed [8:0] pixel_x;
  logic signed [8:0] pixel_y;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic        [7:0] out_byte;
  logic              is_data;
  logic              frame_end;

  oled_page_framebuffer_refresh_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .frame_end (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the display state.
  logic [7:0] column_bytes [STORE_SIZE];
  int stream_page;
  int stream_slot;

  stream_byte_t pending_bytes [$];
  directed_row_t directed [DIRECTED_ROWS];

  // Counters that the checking processes own start at zero as two-state ints.
  int errors;
  int cycles;
  int requests_sent;
  int pixel_writes;
  int data_bytes;
  int command_bytes;
  int frames_seen;
  bit quiet;
  int stall_left;
  int free_left;

  function automatic bit apply_request(input logic [1:0] op, input logic signed [8:0] x,
                                       input logic signed [8:0] y, output stream_byte_t result);
    int col;
    int idx;
    result = '0;
    case (op)
      OP_CLEAR: begin
        foreach (column_bytes[i]) column_bytes[i] = 8'h00;
        return 1'b0;
      end
      OP_SET_PIXEL: begin
        if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT) begin
          idx = (int'(y) / 8) * SCREEN_WIDTH + int'(x);
          column_bytes[idx][y[2:0]] = 1'b1;
        end
        return 1'b0;
      end
      OP_REFRESH: begin
        if (stream_slot < HEADER_SLOTS) begin
          case (hdr_slot_t'(stream_slot[1:0]))
            HDR_PAGE_CMD: result.bits = CMD_PAGE_ADDR;
            HDR_PAGE_NUM: result.bits = 8'(stream_page);
            HDR_COL_LOW:  result.bits = CMD_COL_LOW;
            default:      result.bits = CMD_COL_HIGH;
          endcase
          stream_slot++;
        end else begin
          col = stream_slot - HEADER_SLOTS;
          result.bits = column_bytes[stream_page * SCREEN_WIDTH + col];
          result.data_flag = 1'b1;
          if (col == SCREEN_WIDTH - 1) begin
            result.frame_last = (stream_page == PAGE_COUNT - 1);
            stream_slot = 0;
            stream_page = (stream_page + 1) % PAGE_COUNT;
          end else begin
            stream_slot++;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(input logic [1:0] op, input logic signed [8:0] x,
                       input logic signed [8:0] y, input bit typed, input stream_byte_t want);
    stream_byte_t predicted;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      req_valid <= 1'b0;
      operation <= 2'($urandom);
      pixel_x   <= 9'($urandom);
      pixel_y   <= 9'($urandom);
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    pixel_x   <= x;
    pixel_y   <= y;
    do @(posedge clk); while (req_stall);
    requests_sent++;
    if (op == OP_SET_PIXEL) pixel_writes++;
    if (apply_request(op, x, y, predicted)) pending_bytes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Response side: stall in bursts, with free stretches in between.
  always @(negedge clk) begin
    if (rst || quiet) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      rsp_stall <= 1'b1;
    end else begin
      free_left = $urandom_range(1, 40);
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t ns: unexpected refresh byte %h (is_data %b, frame_end %b)",
                 $time, out_byte, is_data, frame_end);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.bits) begin
          $display("%0t ns: out_byte expected %h, got %h", $time, want.bits, out_byte);
          errors++;
        end
        if (is_data !== want.data_flag) begin
          $display("%0t ns: is_data expected %b, got %b", $time, want.data_flag, is_data);
          errors++;
        end
        if (frame_end !== want.frame_last) begin
          $display("%0t ns: frame_end expected %b, got %b", $time, want.frame_last, frame_end);
          errors++;
        end
      end
      if (is_data) data_bytes++;
      else command_bytes++;
      if (frame_end) frames_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timed out with %0d refresh bytes outstanding",
               $time, pending_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int kind;
    int run;
    int n;
    logic signed [8:0] rx;
    logic signed [8:0] ry;

    rst = 1'b1;
    req_valid = 1'b0;
    operation = OP_CLEAR;
    pixel_x = '0;
    pixel_y = '0;
    requests_sent = 0;
    pixel_writes = 0;
    quiet = 1'b0;
    stream_page = 0;
    stream_slot = 0;
    foreach (column_bytes[i]) column_bytes[i] = 8'h00;

    // Header of page 0, corners, out-of-range writes, the unused code, forwarding and
    // a clear in the middle of a page.
    directed = '{
      '{OP_REFRESH,   0,    0,    1'b1, '{CMD_PAGE_ADDR, 1'b0, 1'b0}},
      '{OP_REFRESH,   0,    0,    1'b1, '{8'h00,         1'b0, 1'b0}},
      '{OP_REFRESH,   0,    0,    1'b1, '{CMD_COL_LOW,   1'b0, 1'b0}},
      '{OP_REFRESH,   0,    0,    1'b1, '{CMD_COL_HIGH,  1'b0, 1'b0}},
      '{OP_SET_PIXEL, 0,    0,    1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 0,    7,    1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 127,  31,   1'b0, NO_BYTE},
      '{OP_SET_PIXEL, -1,   0,    1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 128,  0,    1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 0,    32,   1'b0, NO_BYTE},
      '{OP_SET_PIXEL, -256, -256, 1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 255,  255,  1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 0,    -1,   1'b0, NO_BYTE},
      '{OP_UNUSED,    0,    1,    1'b0, NO_BYTE},
      '{OP_REFRESH,   0,    0,    1'b1, '{8'h81,         1'b1, 1'b0}},
      '{OP_SET_PIXEL, 1,    3,    1'b0, NO_BYTE},
      '{OP_REFRESH,   0,    0,    1'b0, NO_BYTE},
      '{OP_SET_PIXEL, 2,    0,    1'b0, NO_BYTE},
      '{OP_REFRESH,   0,    0,    1'b0, NO_BYTE},
      '{OP_CLEAR,     0,    0,    1'b0, NO_BYTE},
      '{OP_REFRESH,   0,    0,    1'b1, '{8'h00,         1'b1, 1'b0}},
      '{OP_SET_PIXEL, 4,    4,    1'b0, NO_BYTE},
      '{OP_REFRESH,   0,    0,    1'b0, NO_BYTE},
      '{OP_UNUSED,    255,  -256, 1'b0, NO_BYTE}
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      issue(directed[i].op, directed[i].x, directed[i].y, directed[i].typed, directed[i].want);

    // Mostly refresh runs, some long enough to wrap a page, with pixel writes, clears and unused codes in between.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 64);
        repeat (run) issue(OP_REFRESH, 9'($urandom), 9'($urandom), 1'b0, NO_BYTE);
        n += run;
      end else if (kind < 85) begin
        run = $urandom_range(1, 24);
        repeat (run) begin
          if ($urandom_range(0, 5) == 0) begin
            rx = 9'($urandom);
            ry = 9'($urandom);
          end else begin
            rx = 9'($urandom_range(0, SCREEN_WIDTH - 1));
            ry = 9'($urandom_range(0, SCREEN_HEIGHT - 1));
          end
          issue(OP_SET_PIXEL, rx, ry, 1'b0, NO_BYTE);
        end
        n += run;
      end else if (kind < 93) begin
        // A write to the very column the next refresh byte reads, or to column 0 while the stream is in a page header.
        run = $urandom_range(1, 8);
        repeat (run) begin
          rx = 9'((stream_slot >= HEADER_SLOTS) ? stream_slot - HEADER_SLOTS : 0);
          ry = 9'($urandom_range(0, SCREEN_HEIGHT - 1));
          issue(OP_SET_PIXEL, rx, ry, 1'b0, NO_BYTE);
          issue(OP_REFRESH, 9'($urandom), 9'($urandom), 1'b0, NO_BYTE);
        end
        n += 2 * run;
      end else if (kind < 97) begin
        issue(OP_CLEAR, 9'($urandom), 9'($urandom), 1'b0, NO_BYTE);
        n++;
      end else begin
        issue(OP_UNUSED, 9'($urandom), 9'($urandom), 1'b0, NO_BYTE);
        n++;
      end
    end

    req_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d pixel writes); checked %0d command and %0d data bytes,",
             requests_sent, pixel_writes, command_bytes, data_bytes);
    $display("including %0d complete frames.", frames_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
